// ----- sv/nma_pkg.sv -----
// ----------------------------------------------------------------------------
// nma_pkg
// Shared types and fixed widths for the neuron multiply-accumulate and
// activation block.
// ----------------------------------------------------------------------------
`default_nettype none

package nma_pkg;

    localparam int X_W    = 16;
    localparam int W_W    = 16;
    localparam int BIAS_W = 16;
    localparam int PROD_W = 32;
    localparam int ACC_W  = 40;
    localparam int SUM_W  = 24;
    localparam int DER_W  = 13;

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    typedef enum logic [1:0] {
        ACT_RELU     = 2'd0,
        ACT_SOFTPLUS = 2'd1,
        ACT_SIGMOID  = 2'd2,
        ACT_IDENTITY = 2'd3
    } act_mode_t;

    typedef enum logic {
        CFG_BIAS     = 1'b0,
        CFG_ACT_MODE = 1'b1
    } cfg_index_t;

    // Finished dot product handed from the accumulator to the rounding stage.
    typedef struct packed {
        logic signed [ACC_W-1:0] acc;
        act_mode_t               mode;
    } sum_t;

    // Decisions made in the rounding stage for the activation stage.
    typedef struct packed {
        act_mode_t mode;
        logic      clipped;
        logic      ge_hi;
        logic      le_lo;
    } act_ctrl_t;

    typedef struct packed {
        logic                    sum_saturated;
        logic [DER_W-1:0]        derivative;
        logic signed [SUM_W-1:0] activation;
    } result_t;

endpackage

`default_nettype wire

// ----- sv/nma_mac.sv -----
// ----------------------------------------------------------------------------
// nma_mac
// Input register, product register and saturating 40-bit accumulator. The
// finished sum of a vector is held in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module nma_mac #(
    parameter int FRACTION_BITS = 12
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [nma_pkg::X_W-1:0]       in_x,
    input  logic signed [nma_pkg::W_W-1:0]       in_w,
    input  logic                                 in_last,
    input  logic signed [nma_pkg::BIAS_W-1:0]    bias,
    input  nma_pkg::act_mode_t                   mode,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output nma_pkg::sum_t                        out_sum
);

    localparam int ACC_W = nma_pkg::ACC_W;
    localparam int PROD_W = nma_pkg::PROD_W;
    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    logic                               s0_valid_reg;
    logic signed [nma_pkg::X_W-1:0]     x_reg;
    logic signed [nma_pkg::W_W-1:0]     w_reg;
    logic                               s0_last_reg;

    logic                               s1_valid_reg;
    logic signed [PROD_W-1:0]           prod_reg;
    logic signed [PROD_W-1:0]           prod_next;
    logic                               s1_last_reg;

    logic signed [ACC_W-1:0]            acc_reg;
    logic signed [ACC_W-1:0]            acc_next;
    logic                               run_start_reg;

    logic                               s2_valid_reg;
    nma_pkg::sum_t                      sum_reg;

    logic                               s2_free;
    logic                               s1_adv;
    logic                               s1_free;
    logic                               s0_adv;
    logic signed [ACC_W-1:0]            bias_scaled;
    logic signed [ACC_W-1:0]            base;
    logic signed [ACC_W:0]              raw;

    assign s2_free  = !s2_valid_reg || out_ready;
    assign s1_adv   = s1_valid_reg && (!s1_last_reg || s2_free);
    assign s1_free  = !s1_valid_reg || s1_adv;
    assign s0_adv   = s0_valid_reg && s1_free;
    assign in_ready = !s0_valid_reg || s1_free;

    assign prod_next = x_reg * w_reg;

    // A new vector starts from the bias, scaled to the product's fraction bits.
    assign bias_scaled = {{(ACC_W-nma_pkg::BIAS_W){bias[nma_pkg::BIAS_W-1]}}, bias}
                         <<< FRACTION_BITS;
    assign base = run_start_reg ? bias_scaled : acc_reg;
    assign raw  = {base[ACC_W-1], base} + {{(ACC_W+1-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};

    always_comb
    begin
        if (raw[ACC_W] != raw[ACC_W-1])
        begin
            acc_next = raw[ACC_W] ? ACC_MIN : ACC_MAX;
        end
        else
        begin
            acc_next = raw[ACC_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg  <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            acc_reg       <= '0;
            run_start_reg <= 1'b1;
        end
        else
        begin
            if (in_ready)
            begin
                s0_valid_reg <= in_valid;
            end
            if (s1_free)
            begin
                s1_valid_reg <= s0_valid_reg;
            end
            if (s2_free)
            begin
                s2_valid_reg <= s1_adv && s1_last_reg;
            end
            if (s1_adv)
            begin
                acc_reg       <= acc_next;
                run_start_reg <= s1_last_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            x_reg       <= in_x;
            w_reg       <= in_w;
            s0_last_reg <= in_last;
        end
        if (s0_adv)
        begin
            prod_reg    <= prod_next;
            s1_last_reg <= s0_last_reg;
        end
        if (s1_adv && s1_last_reg)
        begin
            sum_reg.acc  <= acc_next;
            sum_reg.mode <= mode;
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_sum   = sum_reg;

endmodule

`default_nettype wire

// ----- sv/nma_round.sv -----
// ----------------------------------------------------------------------------
// nma_round
// Rounds the accumulated sum to the output fraction, saturates it to 24 bits
// and works out the activation table bin and the clamp decisions.
// ----------------------------------------------------------------------------
`default_nettype none

module nma_round #(
    parameter int FRACTION_BITS = 12,
    parameter int TABLE_ENTRIES = 1024
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  nma_pkg::sum_t                        in_sum,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [nma_pkg::SUM_W-1:0]     out_z,
    output logic [$clog2(TABLE_ENTRIES)-1:0]     out_idx,
    output nma_pkg::act_ctrl_t                   out_ctrl
);

    localparam int ACC_W = nma_pkg::ACC_W;
    localparam int SUM_W = nma_pkg::SUM_W;
    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int N_W   = $clog2(TABLE_ENTRIES + 1);
    // The table spans [-16, 16), that is 2^(FRACTION_BITS+5) steps.
    localparam int U_W   = FRACTION_BITS + 5;
    localparam int M_W   = U_W + N_W;
    localparam logic [ACC_W:0] HALF_LSB = (ACC_W+1)'(64'd1 << (FRACTION_BITS - 1));
    localparam logic signed [SUM_W-1:0] CLAMP_HI = SUM_W'(64'd16 << FRACTION_BITS);
    localparam logic signed [SUM_W-1:0] CLAMP_LO = -CLAMP_HI;

    logic                               valid_reg;
    logic signed [SUM_W-1:0]            z_reg;
    logic [IDX_W-1:0]                   idx_reg;
    nma_pkg::act_ctrl_t                 ctrl_reg;

    logic signed [ACC_W:0]              v;
    logic signed [ACC_W:0]              zw;
    logic [ACC_W-SUM_W+1:0]             zw_hi;
    logic                               fits;
    logic signed [SUM_W-1:0]            z_next;
    logic signed [SUM_W-1:0]            zc;
    logic [U_W-1:0]                     u;
    logic [M_W-1:0]                     scaled;
    nma_pkg::act_ctrl_t                 ctrl_next;

    assign in_ready = !valid_reg || out_ready;

    // Round to nearest with ties upward: add half an LSB, then floor.
    assign v     = {in_sum.acc[ACC_W-1], in_sum.acc} + HALF_LSB;
    assign zw    = v >>> FRACTION_BITS;
    assign zw_hi = zw[ACC_W:SUM_W-1];
    assign fits  = (&zw_hi) || !(|zw_hi);

    always_comb
    begin
        if (fits)
        begin
            z_next = zw[SUM_W-1:0];
        end
        else
        begin
            z_next = zw[ACC_W] ? nma_pkg::SUM_MIN : nma_pkg::SUM_MAX;
        end
    end

    assign zc     = z_next + CLAMP_HI;
    assign u      = zc[U_W-1:0];
    assign scaled = M_W'(u) * M_W'(TABLE_ENTRIES);

    always_comb
    begin
        ctrl_next.mode    = in_sum.mode;
        ctrl_next.clipped = !fits;
        ctrl_next.ge_hi   = z_next >= CLAMP_HI;
        ctrl_next.le_lo   = z_next <= CLAMP_LO;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            z_reg    <= z_next;
            idx_reg  <= scaled[U_W +: IDX_W];
            ctrl_reg <= ctrl_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_z     = z_reg;
    assign out_idx   = idx_reg;
    assign out_ctrl  = ctrl_reg;

endmodule

`default_nettype wire

// ----- sv/nma_act.sv -----
// ----------------------------------------------------------------------------
// nma_act
// Activation and derivative selection from the rounded sum and the softplus,
// sigmoid and sigmoid-derivative tables, with the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module nma_act #(
    parameter int FRACTION_BITS = 12,
    parameter int TABLE_ENTRIES = 1024
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [nma_pkg::SUM_W-1:0]     in_z,
    input  logic [$clog2(TABLE_ENTRIES)-1:0]     in_idx,
    input  nma_pkg::act_ctrl_t                   in_ctrl,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output nma_pkg::result_t                     out_result
);

    localparam int SUM_W = nma_pkg::SUM_W;
    localparam int DER_W = nma_pkg::DER_W;
    localparam int QB    = 48;
    localparam logic [63:0] QONE = 64'd1 << QB;
    localparam logic [SUM_W-1:0] ONE_A = SUM_W'(64'd1 << FRACTION_BITS);
    localparam logic [DER_W-1:0] ONE_D = DER_W'(64'd1 << FRACTION_BITS);

    typedef struct packed {
        logic [SUM_W-1:0] sp;
        logic [SUM_W-1:0] sg;
        logic [DER_W-1:0] dsg;
    } rom_entry_t;

    typedef rom_entry_t [TABLE_ENTRIES-1:0] rom_t;

    typedef struct packed {
        logic [63:0] q;
        logic [63:0] r;
    } qr_t;

    // Table contents are computed at elaboration in Q48 fixed point.
    function automatic logic [63:0] mulq(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[QB +: 64];
    endfunction

    function automatic qr_t udivmod(input logic [63:0] n, input logic [63:0] d);
        qr_t res;
        int  i;
        res.q = '0;
        res.r = '0;
        for (i = 63; i >= 0; i--)
        begin
            res.r = {res.r[62:0], n[i]};
            if (res.r >= d)
            begin
                res.r    = res.r - d;
                res.q[i] = 1'b1;
            end
        end
        return res;
    endfunction

    function automatic logic [63:0] divq(input logic [63:0] n, input logic [63:0] d);
        qr_t         qr;
        logic [63:0] q;
        logic [63:0] r;
        int          i;
        qr = udivmod(n, d);
        q  = qr.q;
        r  = qr.r;
        for (i = 0; i < QB; i++)
        begin
            r = r << 1;
            q = q << 1;
            if (r >= d)
            begin
                r    = r - d;
                q[0] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [63:0] exp_pos(input logic [63:0] f);
        logic [63:0] sum;
        logic [63:0] term;
        qr_t         qr;
        int          k;
        sum  = QONE;
        term = QONE;
        for (k = 1; k <= 30; k++)
        begin
            qr   = udivmod(mulq(term, f), 64'(k));
            term = qr.q;
            sum  = sum + term;
        end
        return sum;
    endfunction

    function automatic logic [63:0] round_q(input logic [63:0] v);
        return (v + (64'd1 << (QB - 1 - FRACTION_BITS))) >> (QB - FRACTION_BITS);
    endfunction

    function automatic rom_t build_rom();
        rom_t        rom;
        logic [63:0] einv;
        logic [63:0] n2;
        logic [63:0] k;
        logic [63:0] num;
        logic [63:0] ip;
        logic [63:0] t;
        logic [63:0] e;
        logic [63:0] splus;
        logic [63:0] sminus;
        logic [63:0] y;
        logic [63:0] y2;
        logic [63:0] p;
        logic [63:0] acc;
        logic [63:0] ln1;
        logic [63:0] sp;
        logic [63:0] sg;
        logic [63:0] dsg;
        logic        pos;
        qr_t         qr;
        int          idx;
        int          i;
        einv = divq(QONE, exp_pos(QONE));
        for (idx = 0; idx < TABLE_ENTRIES; idx++)
        begin
            // Bin centre in units of 1/(2*entries) of the full span.
            n2  = 64'(2 * idx + 1);
            pos = n2 > 64'(TABLE_ENTRIES);
            k   = pos ? n2 - 64'(TABLE_ENTRIES) : 64'(TABLE_ENTRIES) - n2;
            num = k * 64'd16;
            ip  = num / TABLE_ENTRIES;
            t   = (ip << QB) + (((num % TABLE_ENTRIES) << QB) / TABLE_ENTRIES);
            e   = divq(QONE, exp_pos(t - (ip << QB)));
            for (i = 0; i < 16; i++)
            begin
                if (64'(i) < ip)
                begin
                    e = mulq(e, einv);
                end
            end
            splus  = divq(QONE, QONE + e);
            sminus = QONE - splus;
            y      = divq(e, 2 * QONE + e);
            y2     = mulq(y, y);
            p      = y;
            acc    = y;
            for (i = 3; i <= 41; i += 2)
            begin
                p   = mulq(p, y2);
                qr  = udivmod(p, 64'(i));
                acc = acc + qr.q;
            end
            ln1 = 2 * acc;
            sp  = round_q(pos ? t + ln1 : ln1);
            sg  = round_q(pos ? splus : sminus);
            dsg = round_q(mulq(splus, sminus));
            rom[idx].sp  = sp[SUM_W-1:0];
            rom[idx].sg  = sg[SUM_W-1:0];
            rom[idx].dsg = dsg[DER_W-1:0];
        end
        return rom;
    endfunction

    localparam rom_t ROM = build_rom();

    logic             valid_reg;
    nma_pkg::result_t result_reg;
    nma_pkg::result_t result_next;
    rom_entry_t       entry;

    assign in_ready = !valid_reg || out_ready;
    assign entry    = ROM[in_idx];

    always_comb
    begin
        result_next.sum_saturated = in_ctrl.clipped;
        result_next.activation    = '0;
        result_next.derivative    = '0;
        case (in_ctrl.mode)
            nma_pkg::ACT_RELU:
            begin
                if (!in_z[SUM_W-1])
                begin
                    result_next.activation = in_z;
                    result_next.derivative = ONE_D;
                end
            end
            nma_pkg::ACT_IDENTITY:
            begin
                result_next.activation = in_z;
                result_next.derivative = ONE_D;
            end
            nma_pkg::ACT_SOFTPLUS:
            begin
                if (in_ctrl.ge_hi)
                begin
                    result_next.activation = in_z;
                    result_next.derivative = ONE_D;
                end
                else if (!in_ctrl.le_lo)
                begin
                    result_next.activation = entry.sp;
                    result_next.derivative = entry.sg[DER_W-1:0];
                end
            end
            nma_pkg::ACT_SIGMOID:
            begin
                if (in_ctrl.ge_hi)
                begin
                    result_next.activation = ONE_A;
                end
                else if (!in_ctrl.le_lo)
                begin
                    result_next.activation = entry.sg;
                    result_next.derivative = entry.dsg;
                end
            end
            default:
            begin
                result_next.activation = in_z;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

endmodule

`default_nettype wire

// ----- sv/neuron_mac_activation_top.sv -----
// ----------------------------------------------------------------------------
// neuron_mac_activation_top
// One streamed neuron: bias plus dot product, then activation and derivative.
// ----------------------------------------------------------------------------
// Each transaction on s_axis carries one (x_value, weight) pair and the block
// takes one per clock cycle unless the result stream stalls, throughput being
// set by the single 16x16 multiply-accumulate stage. The pair marked by tlast
// closes the vector, and its result reaches m_axis through the input register,
// product register, accumulator, rounding stage and result register.
// Only the closing pair produces a result. The sum is rounded to
// FRACTION_BITS fraction bits and saturated to 24 bits, with tuser set when it
// clipped. Softplus and sigmoid come from constant tables of TABLE_ENTRIES bins
// built at elaboration. Write bias and act_mode only while no vector is open.
`default_nettype none

module neuron_mac_activation_top #(
    parameter int TABLE_ENTRIES = 1024,
    parameter int FRACTION_BITS = 12
) (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    // Input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [15:0] x_value, [31:16] weight
    input  logic        s_axis_tlast,
    // Result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [23:0] activation, [36:24] derivative
    output logic        m_axis_tuser    // [0] sum_saturated
);

    localparam int SUM_W = nma_pkg::SUM_W;
    localparam int DER_W = nma_pkg::DER_W;
    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam logic [SUM_W-1:0] ONE_A = SUM_W'(64'd1 << FRACTION_BITS);
    localparam logic [DER_W-1:0] ONE_D = DER_W'(64'd1 << FRACTION_BITS);

    logic signed [nma_pkg::BIAS_W-1:0] bias_reg;
    logic signed [nma_pkg::BIAS_W-1:0] bias_next;
    nma_pkg::act_mode_t                mode_reg;
    nma_pkg::act_mode_t                mode_next;

    logic                              sum_valid;
    logic                              sum_ready;
    nma_pkg::sum_t                     sum;
    logic                              rnd_valid;
    logic                              rnd_ready;
    logic signed [SUM_W-1:0]           rnd_z;
    logic [IDX_W-1:0]                  rnd_idx;
    nma_pkg::act_ctrl_t                rnd_ctrl;
    nma_pkg::result_t                  result;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        bias_next = bias_reg;
        mode_next = mode_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (nma_pkg::cfg_index_t'(cfg_index))
                nma_pkg::CFG_BIAS:     bias_next = cfg_data;
                nma_pkg::CFG_ACT_MODE: mode_next = nma_pkg::act_mode_t'(cfg_data[1:0]);
                default:               bias_next = bias_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bias_reg <= '0;
            mode_reg <= nma_pkg::ACT_RELU;
        end
        else
        begin
            bias_reg <= bias_next;
            mode_reg <= mode_next;
        end
    end

    nma_mac #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_x      (s_axis_tdata[15:0]),
        .in_w      (s_axis_tdata[31:16]),
        .in_last   (s_axis_tlast),
        .bias      (bias_reg),
        .mode      (mode_reg),
        .out_valid (sum_valid),
        .out_ready (sum_ready),
        .out_sum   (sum)
    );

    nma_round #(
        .FRACTION_BITS (FRACTION_BITS),
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_round (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sum_valid),
        .in_ready  (sum_ready),
        .in_sum    (sum),
        .out_valid (rnd_valid),
        .out_ready (rnd_ready),
        .out_z     (rnd_z),
        .out_idx   (rnd_idx),
        .out_ctrl  (rnd_ctrl)
    );

    nma_act #(
        .FRACTION_BITS (FRACTION_BITS),
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_act (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (rnd_valid),
        .in_ready   (rnd_ready),
        .in_z       (rnd_z),
        .in_idx     (rnd_idx),
        .in_ctrl    (rnd_ctrl),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_result (result)
    );

    assign m_axis_tdata = {3'b000, result.derivative, result.activation};
    assign m_axis_tuser = result.sum_saturated;

    // The input side only stalls when every stage behind it is full.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled while the pipeline has room");

    // A clipped sum always ends at a rail: full scale, zero or one.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |->
            m_axis_tdata[SUM_W-1:0] == nma_pkg::SUM_MAX ||
            m_axis_tdata[SUM_W-1:0] == nma_pkg::SUM_MIN ||
            m_axis_tdata[SUM_W-1:0] == '0 ||
            m_axis_tdata[SUM_W-1:0] == ONE_A)
        else $error("clipped sum gave an activation off the rails");

    // The derivative never exceeds one where one fits in the field.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (FRACTION_BITS <= 12) |->
            m_axis_tdata[SUM_W+DER_W-1:SUM_W] <= ONE_D)
        else $error("derivative above one");

endmodule

`default_nettype wire
